// File: hw/rtl/sparse_row_wise_matrix_multiply_unit_assert.svh
// Assertion macros shared by the sparse row-wise multiply unit
`ifndef SPARSE_ROW_WISE_MATRIX_MULTIPLY_UNIT_ASSERT_SVH
`define SPARSE_ROW_WISE_MATRIX_MULTIPLY_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define SRMM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srmm: assertion failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define SRMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srmm: assertion failed");

`endif

// File: hw/rtl/srmm_pkg.sv
// Package: shared types, codes and default sizes of the sparse row-wise multiply unit
`default_nettype none

package srmm_pkg;

  localparam int unsigned DEF_INNER_DIM  = 64;
  localparam int unsigned DEF_OUT_COLS   = 32;
  localparam int unsigned DEF_ROWS       = 1024;
  localparam int unsigned DEF_LIST_DEPTH = 64;
  localparam int unsigned DEF_DATA_WIDTH = 16;

  localparam int unsigned FuncW     = 2;
  localparam int unsigned IdxFieldW = 6;
  localparam int unsigned ColFieldW = 5;
  localparam int unsigned ValueW    = 16;
  localparam int unsigned RowFieldW = 10;

  typedef enum logic [FuncW-1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_B_ENTRY = 2'd1,
    FUNC_A_ENTRY = 2'd2,
    FUNC_ROW_END = 2'd3
  } func_e;

  typedef struct packed {
    logic load;
    logic clear_lists;
    logic b_write;
    logic walk_issue;
    logic emit_issue;
    logic row_adv;
  } dp_cmd_t;

  typedef struct packed {
    logic item_ok;
    logic pipe_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/sparse_row_wise_matrix_multiply_unit.sv
// Operation: clearing the B list lengths takes effect at the transfer, busy stays low; a B nonzero
// keeps busy high through the append state. A nonzero: busy through the walk and drain states
//   (one B entry per cycle through the list store read port, multiplier and accumulator port).
// End of row: busy through the emit state; one registered result per cycle.
// Results cannot be stalled. Reset clears list lengths, accumulator row and row count;
//   B store contents stay undefined until written.
`default_nettype none

module sparse_row_wise_matrix_multiply_unit #(
  parameter int unsigned INNER_DIM  = srmm_pkg::DEF_INNER_DIM,
  parameter int unsigned OUT_COLS   = srmm_pkg::DEF_OUT_COLS,
  parameter int unsigned ROWS       = srmm_pkg::DEF_ROWS,
  parameter int unsigned LIST_DEPTH = srmm_pkg::DEF_LIST_DEPTH,
  parameter int unsigned DATA_WIDTH = srmm_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [srmm_pkg::FuncW-1:0]         func_i,
  input  wire logic [srmm_pkg::IdxFieldW-1:0]     inner_index_i,
  input  wire logic [srmm_pkg::ColFieldW-1:0]     out_col_i,
  input  wire logic signed [srmm_pkg::ValueW-1:0] value_i,
  output logic                                    c_valid_o,
  output logic [srmm_pkg::RowFieldW-1:0]          c_row_o,
  output logic [srmm_pkg::ColFieldW-1:0]          c_col_o,
  output logic signed [srmm_pkg::ValueW-1:0]      c_value_o,
  output logic                                    last_o
);

  localparam int unsigned LenW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CntW =
    $clog2(((LIST_DEPTH > OUT_COLS) ? LIST_DEPTH : OUT_COLS) + 1);

  srmm_pkg::dp_cmd_t  cmd;
  srmm_pkg::dp_stat_t stat;
  logic [LenW-1:0]    len;
  logic [CntW-1:0]    cnt;

  srmm_ctrl #(
    .OUT_COLS  (OUT_COLS),
    .LIST_DEPTH(LIST_DEPTH)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .func_i(func_i),
    .busy  (busy),
    .len_i (len),
    .stat_i(stat),
    .cmd_o (cmd),
    .cnt_o (cnt)
  );

  srmm_dp #(
    .INNER_DIM (INNER_DIM),
    .OUT_COLS  (OUT_COLS),
    .ROWS      (ROWS),
    .LIST_DEPTH(LIST_DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .inner_index_i(inner_index_i),
    .out_col_i    (out_col_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .cnt_i        (cnt),
    .stat_o       (stat),
    .len_o        (len),
    .c_valid_o    (c_valid_o),
    .c_row_o      (c_row_o),
    .c_col_o      (c_col_o),
    .c_value_o    (c_value_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/srmm_dp.sv
// Datapath: item registers, B list store, length table, accumulator row and result stage
`default_nettype none

module srmm_dp #(
  parameter int unsigned INNER_DIM  = srmm_pkg::DEF_INNER_DIM,
  parameter int unsigned OUT_COLS   = srmm_pkg::DEF_OUT_COLS,
  parameter int unsigned ROWS       = srmm_pkg::DEF_ROWS,
  parameter int unsigned LIST_DEPTH = srmm_pkg::DEF_LIST_DEPTH,
  parameter int unsigned DATA_WIDTH = srmm_pkg::DEF_DATA_WIDTH,
  localparam int unsigned LenW = $clog2(LIST_DEPTH + 1),
  localparam int unsigned CntW =
    $clog2(((LIST_DEPTH > OUT_COLS) ? LIST_DEPTH : OUT_COLS) + 1)
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [srmm_pkg::FuncW-1:0]            func_i,
  input  wire logic [srmm_pkg::IdxFieldW-1:0]        inner_index_i,
  input  wire logic [srmm_pkg::ColFieldW-1:0]        out_col_i,
  input  wire logic signed [srmm_pkg::ValueW-1:0]    value_i,
  input  wire srmm_pkg::dp_cmd_t                     cmd_i,
  input  wire logic [CntW-1:0]                       cnt_i,
  output srmm_pkg::dp_stat_t                         stat_o,
  output logic [LenW-1:0]                            len_o,
  output logic                                       c_valid_o,
  output logic [srmm_pkg::RowFieldW-1:0]             c_row_o,
  output logic [srmm_pkg::ColFieldW-1:0]             c_col_o,
  output logic signed [srmm_pkg::ValueW-1:0]         c_value_o,
  output logic                                       last_o
);

  localparam int unsigned IdxW  = (INNER_DIM > 1) ? $clog2(INNER_DIM) : 1;
  localparam int unsigned ColW  = (OUT_COLS > 1) ? $clog2(OUT_COLS) : 1;
  localparam int unsigned RowW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned Depth = INNER_DIM * LIST_DEPTH;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned DW    = DATA_WIDTH;

  logic [DW-1:0]    list_val_mem [Depth];
  logic [ColW-1:0]  list_col_mem [Depth];
  logic [LenW-1:0]  len_mem      [INNER_DIM];
  logic [DW-1:0]    acc_mem      [OUT_COLS];

  logic [INNER_DIM-1:0] len_vld_q;
  logic [OUT_COLS-1:0]  acc_vld_q;

  logic [31:0]      val_ext;
  logic [DW-1:0]    a_in;
  logic             idx_ok;
  logic             col_ok;
  logic             ok_in;
  logic [IdxW-1:0]  idx_in;
  logic [IdxW-1:0]  idx_rd;
  logic [ColW-1:0]  col_in;
  logic [AddrW-1:0] base_in;

  logic [DW-1:0]    a_q;
  logic [IdxW-1:0]  idx_q;
  logic [ColW-1:0]  col_q;
  logic [AddrW-1:0] base_q;
  logic             ok_q;

  logic [LenW-1:0]  len_rd_q;
  logic             len_hit_q;
  logic [LenW-1:0]  len_cur;
  logic [LenW-1:0]  len_nxt;
  logic             b_commit;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] walk_addr;

  logic [DW-1:0]    list_val_rd_q;
  logic [ColW-1:0]  list_col_rd_q;
  logic             s1_vld_q;
  logic [2*DW-1:0]  prod_full;
  logic [DW-1:0]    prod_q;
  logic [ColW-1:0]  s2_col_q;
  logic             s2_vld_q;

  logic [ColW-1:0]  emit_col;
  logic             acc_rd_en;
  logic [ColW-1:0]  acc_rd_addr;
  logic [DW-1:0]    acc_rd_q;
  logic             acc_hit_q;
  logic [DW-1:0]    acc_in;
  logic [DW-1:0]    acc_sum;
  logic [DW-1:0]    fwd_val_q;
  logic [ColW-1:0]  fwd_col_q;
  logic             fwd_vld_q;

  logic [RowW-1:0]  row_q;
  logic [RowW-1:0]  row_d;
  logic             out_vld_q;
  logic [ColW-1:0]  out_col_q;
  logic             out_last_q;
  logic [RowW-1:0]  out_row_q;
  logic [DW-1:0]    out_val;
  logic [31:0]      row_ext;
  logic [31:0]      col_ext;
  logic [31:0]      out_ext;

  // decode the incoming item
  assign val_ext = 32'(value_i);
  assign a_in    = val_ext[DW-1:0];
  assign idx_ok  = 32'(inner_index_i) < INNER_DIM;
  assign col_ok  = 32'(out_col_i) < OUT_COLS;
  assign ok_in   = idx_ok &&
                   ((srmm_pkg::func_e'(func_i) != srmm_pkg::FUNC_B_ENTRY) || col_ok);
  assign idx_in  = IdxW'(inner_index_i);
  assign idx_rd  = idx_ok ? idx_in : '0;
  assign col_in  = ColW'(out_col_i);
  assign base_in = AddrW'(32'(idx_rd) * LIST_DEPTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= a_in;
      idx_q  <= idx_rd;
      col_q  <= col_in;
      base_q <= base_in;
      ok_q   <= ok_in;
    end
  end

  // list lengths
  assign len_cur  = len_hit_q ? len_rd_q : '0;
  assign len_nxt  = len_cur + LenW'(1);
  assign b_commit = cmd_i.b_write && ok_q && (len_cur < LenW'(LIST_DEPTH));
  assign wr_addr  = base_q + AddrW'(len_cur);
  assign walk_addr = base_q + AddrW'(cnt_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      len_rd_q <= len_mem[idx_rd];
    end
    if (b_commit) begin
      len_mem[idx_q] <= len_nxt;
    end
  end

  // B list store
  always_ff @(posedge clk_i) begin
    if (b_commit) begin
      list_val_mem[wr_addr] <= a_q;
      list_col_mem[wr_addr] <= col_q;
    end
    if (cmd_i.walk_issue) begin
      list_val_rd_q <= list_val_mem[walk_addr];
      list_col_rd_q <= list_col_mem[walk_addr];
    end
  end

  // multiply stage and accumulator access
  assign prod_full   = a_q * list_val_rd_q;
  assign emit_col    = cnt_i[ColW-1:0];
  assign acc_rd_en   = s1_vld_q || cmd_i.emit_issue;
  assign acc_rd_addr = s1_vld_q ? list_col_rd_q : emit_col;
  assign acc_in      = (fwd_vld_q && (fwd_col_q == s2_col_q)) ? fwd_val_q :
                       (acc_hit_q ? acc_rd_q : '0);
  assign acc_sum     = acc_in + prod_q;

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_full[DW-1:0];
    s2_col_q  <= list_col_rd_q;
    fwd_val_q <= acc_sum;
    fwd_col_q <= s2_col_q;
    if (acc_rd_en) begin
      acc_rd_q <= acc_mem[acc_rd_addr];
    end
    if (s2_vld_q) begin
      acc_mem[s2_col_q] <= acc_sum;
    end
  end

  // result stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_issue) begin
      out_col_q  <= emit_col;
      out_last_q <= (32'(cnt_i) == (OUT_COLS - 1));
      out_row_q  <= row_q;
    end
  end

  assign row_d = (row_q == RowW'(ROWS - 1)) ? '0 : row_q + RowW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q <= '0;
      len_hit_q <= 1'b0;
      acc_vld_q <= '0;
      acc_hit_q <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      row_q     <= '0;
    end else begin
      s1_vld_q  <= cmd_i.walk_issue;
      s2_vld_q  <= s1_vld_q;
      fwd_vld_q <= s2_vld_q;
      out_vld_q <= cmd_i.emit_issue;
      if (cmd_i.load) begin
        len_hit_q <= len_vld_q[idx_rd];
      end
      if (cmd_i.clear_lists) begin
        len_vld_q <= '0;
      end else if (b_commit) begin
        len_vld_q[idx_q] <= 1'b1;
      end
      if (acc_rd_en) begin
        acc_hit_q <= acc_vld_q[acc_rd_addr];
      end
      if (s2_vld_q) begin
        acc_vld_q[s2_col_q] <= 1'b1;
      end else if (cmd_i.emit_issue) begin
        acc_vld_q[emit_col] <= 1'b0;
      end
      if (cmd_i.row_adv) begin
        row_q <= row_d;
      end
    end
  end

  assign out_val = acc_hit_q ? acc_rd_q : '0;
  assign row_ext = 32'(out_row_q);
  assign col_ext = 32'(out_col_q);
  assign out_ext = 32'(out_val);

  assign c_valid_o = out_vld_q;
  assign c_row_o   = row_ext[srmm_pkg::RowFieldW-1:0];
  assign c_col_o   = col_ext[srmm_pkg::ColFieldW-1:0];
  assign c_value_o = out_ext[srmm_pkg::ValueW-1:0];
  assign last_o    = out_last_q;

  assign len_o            = len_cur;
  assign stat_o.item_ok   = ok_q;
  assign stat_o.pipe_busy = s1_vld_q || s2_vld_q;

endmodule

`default_nettype wire

// File: hw/rtl/srmm_ctrl.sv
// Controller: sequences item loads, B appends, list walks and row emission
`default_nettype none
`include "sparse_row_wise_matrix_multiply_unit_assert.svh"

module srmm_ctrl #(
  parameter int unsigned OUT_COLS   = srmm_pkg::DEF_OUT_COLS,
  parameter int unsigned LIST_DEPTH = srmm_pkg::DEF_LIST_DEPTH,
  localparam int unsigned LenW = $clog2(LIST_DEPTH + 1),
  localparam int unsigned CntW =
    $clog2(((LIST_DEPTH > OUT_COLS) ? LIST_DEPTH : OUT_COLS) + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  input  wire logic [srmm_pkg::FuncW-1:0] func_i,
  output logic                            busy,
  input  wire logic [LenW-1:0]            len_i,
  input  wire srmm_pkg::dp_stat_t         stat_i,
  output srmm_pkg::dp_cmd_t               cmd_o,
  output logic [CntW-1:0]                 cnt_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BWR   = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]      state_q;
  logic [2:0]      state_d;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          unique case (srmm_pkg::func_e'(func_i))
            srmm_pkg::FUNC_CLEAR:   cmd_o.clear_lists = 1'b1;
            srmm_pkg::FUNC_B_ENTRY: state_d = ST_BWR;
            srmm_pkg::FUNC_A_ENTRY: state_d = ST_WALK;
            srmm_pkg::FUNC_ROW_END: state_d = ST_EMIT;
          endcase
        end
      end
      ST_BWR: begin
        cmd_o.b_write = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_WALK: begin
        if (stat_i.item_ok && (cnt_q < CntW'(len_i))) begin
          cmd_o.walk_issue = 1'b1;
          cnt_d            = cnt_q + CntW'(1);
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_issue = 1'b1;
        cnt_d            = cnt_q + CntW'(1);
        if (cnt_q == CntW'(OUT_COLS - 1)) begin
          cmd_o.row_adv = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy  = (state_q != ST_IDLE);
  assign cnt_o = cnt_q;

  `SRMM_ASSERT_NOW(a_emit_after_drain, cmd_o.emit_issue, !stat_i.pipe_busy)
  `SRMM_ASSERT_NOW(a_emit_col_range, state_q == ST_EMIT, cnt_q < CntW'(OUT_COLS))
  `SRMM_ASSERT_NEXT(a_busy_after_transfer, start && !busy && (func_i != srmm_pkg::FUNC_CLEAR), busy)

endmodule

`default_nettype wire
